FILE: sv/tle_pkg.sv
// tle_pkg: shared types, key codes and limits for the terminal line editor
// no dependencies
`default_nettype none

package tle_pkg;

  localparam int MAX_LINE = 128;
  localparam int LIMIT_CAP = (MAX_LINE > 255) ? 255 : MAX_LINE;

  localparam logic [7:0] LINE_LIMIT_RESET = 8'd128;

  localparam logic [7:0] KEY_BS      = 8'h08;
  localparam logic [7:0] KEY_LF      = 8'h0A;
  localparam logic [7:0] KEY_CR      = 8'h0D;
  localparam logic [7:0] KEY_ESC     = 8'h1B;
  localparam logic [7:0] KEY_SPACE   = 8'h20;
  localparam logic [7:0] KEY_UPPER_Z = 8'h5A;
  localparam logic [7:0] KEY_LOWER_A = 8'h61;
  localparam logic [7:0] KEY_LOWER_Z = 8'h7A;
  localparam logic [7:0] KEY_DEL     = 8'h7F;
  localparam logic [7:0] KEY_LBRACK  = 8'h5B;
  localparam logic [7:0] KEY_ARROW_L = 8'h44;
  localparam logic [7:0] KEY_ARROW_R = 8'h43;

  typedef enum logic [2:0] {
    ESC_NONE    = 3'b001,
    ESC_SEEN    = 3'b010,
    ESC_BRACKET = 3'b100
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] char_count;
    logic [7:0] cursor_column;
    esc_phase_t phase;
  } line_state_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [6:0] store_index;
    logic [7:0] store_byte;
    logic       line_done;
    logic [7:0] line_length;
    logic       end_reason;
    logic       last;
  } result_t;

  // beats: 0 none, 1 single result, 3 echo triple
  typedef struct packed {
    logic [1:0] beats;
    result_t    first;
    logic [7:0] echo1;
    logic [7:0] echo2;
  } plan_t;

endpackage

`default_nettype wire

FILE: sv/tle_decode.sv
// tle_decode: per-byte edit logic, next line state and result plan
// depends on tle_pkg
`default_nettype none

module tle_decode
  import tle_pkg::*;
(
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  limit,
  input  wire line_state_t cur,
  output line_state_t      nxt,
  output plan_t            plan
);

  line_state_t cleared;
  logic [7:0]  new_count;
  logic        printable;

  assign cleared   = '{char_count: 8'd0, cursor_column: 8'd0, phase: ESC_NONE};
  assign new_count = cur.char_count + 8'd1;
  assign printable = ((rx_byte >= KEY_SPACE) && (rx_byte <= KEY_UPPER_Z)) ||
                     ((rx_byte >= KEY_LOWER_A) && (rx_byte <= KEY_LOWER_Z));

  always_comb begin
    nxt  = cur;
    plan = '0;
    unique case (cur.phase)
      ESC_SEEN: begin
        nxt.phase = (rx_byte == KEY_LBRACK) ? ESC_BRACKET : ESC_NONE;
      end
      ESC_BRACKET: begin
        nxt.phase = ESC_NONE;
        if ((rx_byte == KEY_ARROW_L) && (cur.cursor_column != 8'd0)) begin
          nxt.cursor_column         = cur.cursor_column - 8'd1;
          plan.beats                = 2'd3;
          plan.first.echo_valid     = 1'b1;
          plan.first.echo_byte      = KEY_ESC;
          plan.echo1                = KEY_LBRACK;
          plan.echo2                = KEY_ARROW_L;
        end else if ((rx_byte == KEY_ARROW_R) &&
                     (cur.cursor_column < cur.char_count)) begin
          nxt.cursor_column         = cur.cursor_column + 8'd1;
          plan.beats                = 2'd3;
          plan.first.echo_valid     = 1'b1;
          plan.first.echo_byte      = KEY_ESC;
          plan.echo1                = KEY_LBRACK;
          plan.echo2                = KEY_ARROW_R;
        end
      end
      ESC_NONE: begin
        priority if ((rx_byte == KEY_CR) || (rx_byte == KEY_LF)) begin
          nxt                    = cleared;
          plan.beats             = 2'd1;
          plan.first.line_done   = 1'b1;
          plan.first.line_length = cur.char_count;
          plan.first.last        = 1'b1;
        end else if ((rx_byte == KEY_BS) || (rx_byte == KEY_DEL)) begin
          if (cur.char_count != 8'd0) begin
            nxt.char_count        = cur.char_count - 8'd1;
            plan.beats            = 2'd3;
            plan.first.echo_valid = 1'b1;
            plan.first.echo_byte  = KEY_BS;
            plan.echo1            = KEY_SPACE;
            plan.echo2            = KEY_BS;
          end
        end else if (rx_byte == KEY_ESC) begin
          nxt.phase = ESC_SEEN;
        end else if (printable) begin
          plan.beats             = 2'd1;
          plan.first.echo_valid  = 1'b1;
          plan.first.echo_byte   = rx_byte;
          plan.first.store_valid = 1'b1;
          plan.first.store_index = cur.char_count[6:0];
          plan.first.store_byte  = rx_byte;
          plan.first.last        = 1'b1;
          if (new_count >= limit) begin
            nxt                    = cleared;
            plan.first.line_done   = 1'b1;
            plan.first.line_length = new_count;
            plan.first.end_reason  = 1'b1;
          end else begin
            nxt.char_count    = new_count;
            nxt.cursor_column = (cur.cursor_column != 8'hFF) ?
                                cur.cursor_column + 8'd1 : cur.cursor_column;
          end
        end
      end
      default: begin
        nxt.phase = ESC_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/tle_seq.sv
// tle_seq: result register and sequencer, one beat per cycle from a plan while out_ready is high
// depends on tle_pkg
`default_nettype none

module tle_seq
  import tle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load,
  input  wire plan_t plan,
  output logic       free,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    res
);

  logic [1:0] cnt;
  logic [7:0] pend1;
  logic [7:0] pend2;
  logic       beat;

  assign beat      = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign free      = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= plan.beats;
    end else if (beat) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res   <= plan.first;
      pend1 <= plan.echo1;
      pend2 <= plan.echo2;
    end else if (beat && (cnt > 2'd1)) begin
      res.echo_byte <= pend1;
      res.last      <= (cnt == 2'd2);
      pend1         <= pend2;
    end
  end

  a_more_after_mid: assert property (@(posedge clk) disable iff (rst)
    beat && !res.last |=> out_valid)
    else $error("beat without last not followed by another beat");

  a_no_echo_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.echo_valid |-> res.last && res.line_done)
    else $error("result without echo must be a final line completion");

  a_store_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.store_valid |-> res.echo_valid && res.last)
    else $error("store beat must echo and be final");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free && (plan.beats == 2'd1 || plan.beats == 2'd3))
    else $error("plan loaded while busy or with bad beat count");

endmodule

`default_nettype wire

FILE: sv/terminal_line_editor.sv
// terminal_line_editor: top level, input register, line state and limit register
// depends on tle_pkg, tle_decode, tle_seq
`default_nettype none

// Edits one terminal input line. A received byte enters an input register,
// is decoded against the line state, and its results leave through a result
// register, one beat per cycle while out_ready is high. Bytes giving no result
// or one result can be accepted every cycle while out_ready is high; backspace
// and arrow keys that take effect give three echo beats, and a next byte that gives
// a result waits until the last is taken. The user must write line_limit through
// line_limit_we / line_limit_wdata only while idle; not enforced by the block.
module terminal_line_editor
  import tle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       line_limit_we,
  input  wire logic [7:0] line_limit_wdata,
  input  wire logic       rx_valid,
  output logic            rx_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            echo_valid,
  output logic [7:0]      echo_byte,
  output logic            store_valid,
  output logic [6:0]      store_index,
  output logic [7:0]      store_byte,
  output logic            line_done,
  output logic [7:0]      line_length,
  output logic            end_reason,
  output logic            last
);

  logic [7:0]  line_limit;
  logic [7:0]  limit_eff;
  logic        in_full;
  logic [7:0]  in_byte;
  line_state_t line_state;
  line_state_t line_state_next;
  plan_t       plan;
  logic        seq_free;
  logic        advance;
  result_t     res;

  assign limit_eff = (line_limit > 8'(LIMIT_CAP)) ? 8'(LIMIT_CAP) :
                     (line_limit == 8'd0) ? 8'd1 : line_limit;

  assign advance  = in_full && ((plan.beats == 2'd0) || seq_free);
  assign rx_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LINE_LIMIT_RESET;
    end else if (line_limit_we) begin
      line_limit <= line_limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state <= '{char_count: 8'd0, cursor_column: 8'd0, phase: ESC_NONE};
    end else if (advance) begin
      line_state <= line_state_next;
    end
  end

  tle_decode u_decode (
    .rx_byte (in_byte),
    .limit   (limit_eff),
    .cur     (line_state),
    .nxt     (line_state_next),
    .plan    (plan)
  );

  tle_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && (plan.beats != 2'd0)),
    .plan      (plan),
    .free      (seq_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign echo_valid  = res.echo_valid;
  assign echo_byte   = res.echo_byte;
  assign store_valid = res.store_valid;
  assign store_index = res.store_index;
  assign store_byte  = res.store_byte;
  assign line_done   = res.line_done;
  assign line_length = res.line_length;
  assign end_reason  = res.end_reason;
  assign last        = res.last;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for terminal_line_editor
// depends on tle_pkg and terminal_line_editor; line editor predictor and result scoreboard
`timescale 1ns / 100ps

module tb_top
  import tle_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;

  localparam logic [1:0] RDY_ALWAYS = 2'd0;
  localparam logic [1:0] RDY_RANDOM = 2'd1;
  localparam logic [1:0] RDY_SPARSE = 2'd2;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       line_limit_we = 1'b0;
  logic [7:0] line_limit_wdata = 8'd0;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       store_valid;
  logic [6:0] store_index;
  logic [7:0] store_byte;
  logic       line_done;
  logic [7:0] line_length;
  logic       end_reason;
  logic       last;

  terminal_line_editor i_dut (
    .clk              (clk),
    .rst              (rst),
    .line_limit_we    (line_limit_we),
    .line_limit_wdata (line_limit_wdata),
    .rx_valid         (rx_valid),
    .rx_ready         (rx_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .echo_valid       (echo_valid),
    .echo_byte        (echo_byte),
    .store_valid      (store_valid),
    .store_index      (store_index),
    .store_byte       (store_byte),
    .line_done        (line_done),
    .line_length      (line_length),
    .end_reason       (end_reason),
    .last             (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // line editor predictor state
  logic [7:0] model_limit  = LINE_LIMIT_RESET;
  logic [7:0] model_count  = 8'd0;
  logic [7:0] model_cursor = 8'd0;
  esc_phase_t model_phase  = ESC_NONE;

  result_t pending_results[$];
  int      error_count = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;

  function automatic void push_echo_triple(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    result_t r;
    r = '0;
    r.echo_valid = 1'b1;
    r.echo_byte  = a;
    pending_results.push_back(r);
    r.echo_byte  = b;
    pending_results.push_back(r);
    r.echo_byte  = c;
    r.last       = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void clear_line_model();
    model_count  = 8'd0;
    model_cursor = 8'd0;
    model_phase  = ESC_NONE;
  endfunction

  function automatic void predict_edit(input logic [7:0] b);
    int         lim;
    logic [7:0] pos;
    result_t    r;
    lim = (int'(model_limit) > MAX_LINE) ? MAX_LINE : int'(model_limit);
    if (lim == 0) lim = 1;
    r = '0;
    if (model_phase == ESC_SEEN) begin
      model_phase = (b == KEY_LBRACK) ? ESC_BRACKET : ESC_NONE;
    end else if (model_phase == ESC_BRACKET) begin
      model_phase = ESC_NONE;
      if (b == KEY_ARROW_L && model_cursor > 0) begin
        model_cursor = model_cursor - 8'd1;
        push_echo_triple(KEY_ESC, KEY_LBRACK, KEY_ARROW_L);
      end else if (b == KEY_ARROW_R && model_cursor < model_count) begin
        model_cursor = model_cursor + 8'd1;
        push_echo_triple(KEY_ESC, KEY_LBRACK, KEY_ARROW_R);
      end
    end else if (b == KEY_CR || b == KEY_LF) begin
      r.line_done   = 1'b1;
      r.line_length = model_count;
      r.last        = 1'b1;
      pending_results.push_back(r);
      clear_line_model();
    end else if (b == KEY_BS || b == KEY_DEL) begin
      if (model_count != 0) begin
        model_count = model_count - 8'd1;
        push_echo_triple(KEY_BS, KEY_SPACE, KEY_BS);
      end
    end else if (b == KEY_ESC) begin
      model_phase = ESC_SEEN;
    end else if ((b >= KEY_SPACE && b <= KEY_UPPER_Z) ||
                 (b >= KEY_LOWER_A && b <= KEY_LOWER_Z)) begin
      pos = model_count;
      model_count = model_count + 8'd1;
      if (model_cursor != 8'hFF) model_cursor = model_cursor + 8'd1;
      r.echo_valid  = 1'b1;
      r.echo_byte   = b;
      r.store_valid = 1'b1;
      r.store_index = pos[6:0];
      r.store_byte  = b;
      r.last        = 1'b1;
      if (int'(model_count) >= lim) begin
        r.line_done   = 1'b1;
        r.line_length = model_count;
        r.end_reason  = 1'b1;
        clear_line_model();
      end
      pending_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // scoreboard: check result beats first, then predict accepted bytes
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_line_model();
      model_limit = LINE_LIMIT_RESET;
    end else begin
      if (line_limit_we) model_limit = line_limit_wdata;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with no expectation, echo %0h store %0h done %0b",
                   $time, echo_byte, store_byte, line_done);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("echo_valid", 8'(want.echo_valid), 8'(echo_valid));
          check_field("echo_byte", want.echo_byte, echo_byte);
          check_field("store_valid", 8'(want.store_valid), 8'(store_valid));
          check_field("store_index", 8'(want.store_index), 8'(store_index));
          check_field("store_byte", want.store_byte, store_byte);
          check_field("line_done", 8'(want.line_done), 8'(line_done));
          check_field("line_length", want.line_length, line_length);
          check_field("end_reason", 8'(want.end_reason), 8'(end_reason));
          check_field("last", 8'(want.last), 8'(last));
        end
      end
      if (rx_valid && rx_ready) predict_edit(rx_byte);
    end
  end

  // receiver stall pattern
  logic [7:0] stall_tick = 8'd0;
  logic [1:0] stall_mode = RDY_ALWAYS;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 2));
    case (stall_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
      default:    out_ready <= (stall_tick[1:0] == 2'b11);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    burst_left--;
  endtask

  // hold the sender until every expected beat has arrived
  task automatic wait_line_idle();
    rx_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_limit(input logic [7:0] v);
    line_limit_we    <= 1'b1;
    line_limit_wdata <= v;
    @(posedge clk);
    line_limit_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sequence(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  function automatic logic [7:0] random_printable();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(KEY_SPACE, KEY_UPPER_Z));
    return 8'($urandom_range(KEY_LOWER_A, KEY_LOWER_Z));
  endfunction

  task automatic test_edit_keys();
    send_sequence('{KEY_SPACE, KEY_UPPER_Z, KEY_LOWER_A, KEY_LOWER_Z});
    send_sequence('{8'h00, 8'h1F, KEY_LBRACK, 8'h60, 8'h7B, 8'h80, 8'hFF});
    send_sequence('{KEY_ESC, KEY_LBRACK, KEY_ARROW_L});
    send_sequence('{KEY_ESC, KEY_LBRACK, KEY_ARROW_R});
    send_sequence('{KEY_ESC, KEY_LBRACK, KEY_ARROW_R});
    send_sequence('{KEY_ESC, KEY_LOWER_A, KEY_ESC, KEY_LBRACK, KEY_CR});
    send_sequence('{KEY_BS, KEY_DEL, KEY_CR, KEY_LF, KEY_BS});
    send_sequence('{KEY_ESC, KEY_LBRACK, KEY_ARROW_L});
    wait_line_idle();
  endtask

  task automatic test_full_line();
    write_line_limit(8'd3);
    send_sequence('{KEY_LOWER_A, 8'h62, 8'h63});
    wait_line_idle();
    write_line_limit(8'd0);
    send_sequence('{KEY_UPPER_Z, KEY_SPACE});
    wait_line_idle();
  endtask

  task automatic test_limit_lowered();
    write_line_limit(8'd128);
    send_sequence('{8'h41, 8'h42, 8'h43, 8'h44, 8'h45});
    wait_line_idle();
    write_line_limit(8'd2);
    send_byte(8'h46);
    wait_line_idle();
  endtask

  task automatic test_random_editing(input logic [7:0] limit, input int n, input int nl_pct);
    int sent;
    int pick;
    write_line_limit(limit);
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < nl_pct) begin
        send_byte($urandom_range(0, 1) ? KEY_CR : KEY_LF);
        sent += 1;
      end else if (pick < nl_pct + 8) begin
        send_byte($urandom_range(0, 1) ? KEY_BS : KEY_DEL);
        sent += 1;
      end else if (pick < nl_pct + 16) begin
        send_sequence('{KEY_ESC, KEY_LBRACK,
                        $urandom_range(0, 1) ? KEY_ARROW_L : KEY_ARROW_R});
        sent += 3;
      end else if (pick < nl_pct + 20) begin
        if ($urandom_range(0, 1)) begin
          send_sequence('{KEY_ESC, 8'($urandom_range(0, 255))});
          sent += 2;
        end else begin
          send_sequence('{KEY_ESC, KEY_LBRACK, 8'($urandom_range(0, 255))});
          sent += 3;
        end
      end else if (pick < nl_pct + 26) begin
        send_byte(8'($urandom_range(0, 255)));
        sent += 1;
      end else begin
        send_byte(random_printable());
        sent += 1;
      end
    end
    wait_line_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edit_keys();
    test_full_line();
    test_limit_lowered();
    test_random_editing(8'd128, 150, 1);
    test_random_editing(8'd1, 40, 10);
    test_random_editing(8'd255, 60, 4);
    test_random_editing(8'd7, 60, 8);
    test_random_editing(8'($urandom_range(1, 128)), 60, 5);
    test_random_editing(8'd0, 30, 10);
    test_random_editing(8'd2, 40, 10);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tle_pkg.sv
sv/tle_decode.sv
sv/tle_seq.sv
sv/terminal_line_editor.sv
tb/tb_top.sv
